// ===== hw/rtl/text_console_writer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Concurrent assertion wrappers clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define TWC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("twc assertion failed");

`define TWC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("twc assertion failed");

`else

`define TWC_ASSERT_SAME(label, ante, cons)

`define TWC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/twc_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console writer package
// Shared constants, field widths, controller states and command/status types.
// ----------------------------------------------------------------------------
package twc_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int LINES_DEF   = 25;

    localparam int CHAR_W     = 8;
    localparam int INDEX_W    = 11;
    localparam int POS_OUT_W  = 11;
    localparam int CELL_W     = 16;
    localparam int COLOUR_W   = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;

    localparam logic [CHAR_W-1:0]    NEWLINE_CODE = 8'd10;
    localparam logic [COLOUR_W-1:0]  FG_RESET     = 4'hF;
    localparam logic [COLOUR_W-1:0]  BG_RESET     = 4'h0;

    localparam logic                 KIND_PUT     = 1'b0;
    localparam logic                 KIND_READ    = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FG       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG       = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_CLEAR_END,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_SCROLL_END,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic sweep_run;
        logic sweep_clear;
        logic read_capture;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_read;
        logic needs_scroll;
        logic sweep_last;
        logic out_free;
    } status_t;

endpackage

// ===== hw/rtl/twc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences reset clearing, item handling, scroll sweeps and result hand-off.
// ----------------------------------------------------------------------------
module twc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  twc_pkg::status_t status,
    output twc_pkg::cmd_t    cmd
);
    import twc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep_run   = 1'b1;
                cmd.sweep_clear = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_CLEAR_END;
                end
            end
            ST_CLEAR_END:
            begin
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    priority if (status.is_read)
                    begin
                        state_next = ST_READ;
                    end
                    else if (status.needs_scroll)
                    begin
                        state_next = ST_SCROLL;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_READ:
            begin
                cmd.read_capture = 1'b1;
                state_next       = ST_DONE;
            end
            ST_SCROLL:
            begin
                cmd.sweep_run = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_SCROLL_END;
                end
            end
            ST_SCROLL_END:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== hw/rtl/twc_datapath.sv =====
// ----------------------------------------------------------------------------
// Text console writer datapath
// Cell store, cursor, colour registers, sweep engine and result register.
// ----------------------------------------------------------------------------
`include "text_console_writer_core_defines.svh"

module twc_datapath #(
    parameter int COLUMNS = twc_pkg::COLUMNS_DEF,
    parameter int LINES   = twc_pkg::LINES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  twc_pkg::cmd_t                   cmd,
    output twc_pkg::status_t                status,
    input  logic                            in_kind,
    input  logic [twc_pkg::CHAR_W-1:0]      in_char,
    input  logic [twc_pkg::INDEX_W-1:0]     in_index,
    input  logic                            cfg_valid,
    input  logic [twc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [twc_pkg::COLOUR_W-1:0]    cfg_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [twc_pkg::POS_OUT_W-1:0]   out_pos,
    output logic                            out_scrolled,
    output logic [twc_pkg::CELL_W-1:0]      out_data,
    output logic                            out_read_valid
);
    import twc_pkg::*;

    localparam int CELLS = COLUMNS * LINES;
    localparam int POS_W = $clog2(CELLS);
    localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W = $clog2(LINES);
    localparam int CMP_W = ((POS_W > INDEX_W) ? POS_W : INDEX_W) + 1;

    localparam logic [POS_W-1:0] LAST_POS   = POS_W'(CELLS - 1);
    localparam logic [POS_W-1:0] BOTTOM_POS = POS_W'(CELLS - COLUMNS);
    localparam logic [POS_W-1:0] ROW_STEP   = POS_W'(COLUMNS);
    localparam logic [COL_W-1:0] LAST_COL   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(LINES - 1);
    localparam logic [CMP_W-1:0] CELLS_CMP  = CMP_W'(CELLS);

    logic [COLOUR_W-1:0]  fg_reg;
    logic [COLOUR_W-1:0]  bg_reg;
    logic [COL_W-1:0]     col_reg;
    logic [COL_W-1:0]     col_next;
    logic [ROW_W-1:0]     row_reg;
    logic [ROW_W-1:0]     row_next;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;

    logic [CELL_W-1:0]    mem [CELLS];
    logic [CELL_W-1:0]    mem_rdata_reg;
    logic [POS_W-1:0]     rd_addr;

    logic [POS_W-1:0]     sweep_idx_reg;
    logic [POS_W-1:0]     sweep_src;
    logic                 wr_en_reg;
    logic [POS_W-1:0]     wr_addr_reg;
    logic                 wr_zero_reg;
    logic [CELL_W-1:0]    sweep_data;

    logic                 oor_reg;
    logic                 res_scroll_reg;
    logic                 res_rdv_reg;
    logic [CELL_W-1:0]    res_data_reg;

    logic                 out_valid_reg;
    logic [POS_OUT_W-1:0] out_pos_reg;
    logic                 out_scrolled_reg;
    logic [CELL_W-1:0]    out_data_reg;
    logic                 out_read_valid_reg;

    logic                 is_put;
    logic                 is_newline;
    logic                 row_adv;
    logic                 scroll_hit;
    logic                 put_wr_en;
    logic [CELL_W-1:0]    put_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= FG_RESET;
            bg_reg <= BG_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FG:  fg_reg <= cfg_data;
                CFG_BG:  bg_reg <= cfg_data;
            endcase
        end
    end

    assign is_put     = (in_kind == KIND_PUT);
    assign is_newline = (in_char == NEWLINE_CODE);
    assign row_adv    = is_newline || (col_reg == LAST_COL);
    assign scroll_hit = row_adv && (row_reg == LAST_ROW);
    assign put_wr_en  = cmd.accept && is_put && !is_newline;
    assign put_data   = {bg_reg, fg_reg, in_char};

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        pos_next = pos_reg;
        if (cmd.accept && is_put)
        begin
            priority if (scroll_hit)
            begin
                col_next = '0;
                row_next = LAST_ROW;
                pos_next = BOTTOM_POS;
            end
            else if (row_adv)
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
                pos_next = is_newline ? (pos_reg - POS_W'(col_reg) + ROW_STEP)
                                      : (pos_reg + 1'b1);
            end
            else
            begin
                col_next = col_reg + 1'b1;
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            pos_reg <= pos_next;
        end
    end

    assign sweep_src  = sweep_idx_reg + ROW_STEP;
    assign rd_addr    = cmd.accept ? POS_W'(in_index) : sweep_src;
    assign sweep_data = wr_zero_reg ? '0 : mem_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (put_wr_en)
        begin
            mem[pos_reg] <= put_data;
        end
        else if (wr_en_reg)
        begin
            mem[wr_addr_reg] <= sweep_data;
        end
        mem_rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_idx_reg <= '0;
            wr_en_reg     <= 1'b0;
        end
        else
        begin
            wr_en_reg <= cmd.sweep_run;
            if (cmd.sweep_run)
            begin
                sweep_idx_reg <= status.sweep_last ? '0 : (sweep_idx_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= sweep_idx_reg;
        wr_zero_reg <= cmd.sweep_clear || (sweep_idx_reg >= BOTTOM_POS);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            oor_reg        <= !(CMP_W'(in_index) < CELLS_CMP);
            res_scroll_reg <= is_put && scroll_hit;
            res_rdv_reg    <= (in_kind == KIND_READ);
            res_data_reg   <= '0;
        end
        else if (cmd.read_capture)
        begin
            res_data_reg <= oor_reg ? '0 : mem_rdata_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_pos_reg        <= POS_OUT_W'(pos_reg);
            out_scrolled_reg   <= res_scroll_reg;
            out_data_reg       <= res_data_reg;
            out_read_valid_reg <= res_rdv_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_pos        = out_pos_reg;
    assign out_scrolled   = out_scrolled_reg;
    assign out_data       = out_data_reg;
    assign out_read_valid = out_read_valid_reg;

    assign status.is_read      = (in_kind == KIND_READ);
    assign status.needs_scroll = scroll_hit;
    assign status.sweep_last   = (sweep_idx_reg == LAST_POS);
    assign status.out_free     = !out_valid_reg || out_ready;

    `TWC_ASSERT_SAME(a_single_writer, put_wr_en, !wr_en_reg)
    `TWC_ASSERT_SAME(a_cursor_linear, 1'b1,
        (32'(pos_reg) == 32'(row_reg) * COLUMNS + 32'(col_reg)) && (row_reg <= LAST_ROW))
    `TWC_ASSERT_NEXT(a_sweep_wraps, cmd.sweep_run && status.sweep_last,
        (sweep_idx_reg == '0) && wr_en_reg)

endmodule

// ===== hw/rtl/text_console_writer_core.sv =====
// ----------------------------------------------------------------------------
// Text console writer core
// Character console over a LINES x COLUMNS store of 16-bit attribute cells.
//
//   channel   handshake                   payload
//   s_*       s_tvalid / s_tready         tdata: char_code, read_index; tuser: kind
//   m_*       m_tvalid / m_tready         tdata: cursor_pos, scrolled, read_data;
//                                         tuser: read_valid
//   cfg_*     cfg_valid / cfg_ready       cfg_index, cfg_data (colour nibble)
//
// A read item passes through an extra state beyond a put (registered store read).
// A put that scrolls adds a sweep of the store: one cell moved per cycle
// through the single read and write port of the store.
// After reset the store is cleared one cell per cycle while s_tready stays
// low; configuration writes are taken throughout.
// A stalled result is held in the output register; the next item is
// accepted meanwhile and waits for that register before its result is shown.
// ----------------------------------------------------------------------------
module text_console_writer_core #(
    parameter int COLUMNS = twc_pkg::COLUMNS_DEF,
    parameter int LINES   = twc_pkg::LINES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [twc_pkg::S_TDATA_W-1:0]   s_tdata,   // char_code[7:0], read_index[18:8]
    input  logic                            s_tuser,   // kind[0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [twc_pkg::M_TDATA_W-1:0]   m_tdata,   // cursor_pos[10:0], scrolled[11],
                                                       // read_data[27:12]
    output logic                            m_tuser,   // read_valid[0]
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [twc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [twc_pkg::COLOUR_W-1:0]    cfg_data
);
    import twc_pkg::*;

    cmd_t                 cmd;
    status_t              status;
    logic [POS_OUT_W-1:0] out_pos;
    logic                 out_scrolled;
    logic [CELL_W-1:0]    out_data;

    assign cfg_ready = 1'b1;

    twc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    twc_datapath #(
        .COLUMNS (COLUMNS),
        .LINES   (LINES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_kind        (s_tuser),
        .in_char        (s_tdata[CHAR_W-1:0]),
        .in_index       (s_tdata[CHAR_W+INDEX_W-1:CHAR_W]),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_pos        (out_pos),
        .out_scrolled   (out_scrolled),
        .out_data       (out_data),
        .out_read_valid (m_tuser)
    );

    assign m_tdata = {{(M_TDATA_W - POS_OUT_W - 1 - CELL_W){1'b0}},
                      out_data, out_scrolled, out_pos};

endmodule
